@@ rtl/rgbluv_pkg.sv @@
// Shared constants and elaboration helpers for the RGB to Luv converter.
package rgbluv_pkg;

  localparam int CHAN_W  = 16;
  localparam int COEF_W  = 20;
  localparam int PROD_W  = CHAN_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  // Z row sums above one, so Zq needs one integer bit
  localparam int XQ_W    = 21;
  localparam int DEN_W   = 25;
  localparam int NUM_W   = 47;
  localparam int QUO_W   = 26;
  localparam int DIFF_W  = 28;
  localparam int TERM_W  = DIFF_W + CHAN_W;
  localparam int ACC_W   = TERM_W + 2;

  // Matrix and white point, Q0.20, rounded from six decimal places
  localparam logic [COEF_W-1:0] KXR = COEF_W'((64'd430574 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KXG = COEF_W'((64'd341550 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KXB = COEF_W'((64'd178325 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KYR = COEF_W'((64'd222015 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KYG = COEF_W'((64'd706655 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KYB = COEF_W'((64'd71330 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KZR = COEF_W'((64'd20183 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KZG = COEF_W'((64'd129553 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] KZB = COEF_W'((64'd939180 * 64'd1048576 + 64'd500000) / 64'd1000000);
  localparam logic [DIFF_W-1:0] WHITE_U13 =
    DIFF_W'(64'd13 * ((64'd197833 * 64'd1048576 + 64'd500000) / 64'd1000000));
  localparam logic [DIFF_W-1:0] WHITE_V13 =
    DIFF_W'(64'd13 * ((64'd468331 * 64'd1048576 + 64'd500000) / 64'd1000000));
  localparam logic [CHAN_W-1:0] OFF_U = CHAN_W'((64'd88 * 64'd65536 + 64'd135) / 64'd270);
  localparam logic [CHAN_W-1:0] OFF_V = CHAN_W'((64'd134 * 64'd65536 + 64'd135) / 64'd270);

  // floor(cbrt(i/steps) * 2^17) by bitwise search, used at elaboration only
  function automatic longint unsigned cbrt_q17(longint unsigned i, longint unsigned steps);
    longint unsigned c;
    longint unsigned cand;
    longint unsigned target;
    c = 64'd0;
    target = i << 51;
    if (i >= steps) begin
      c = 64'd1 << 17;
    end else begin
      for (int b = 16; b >= 0; b--) begin
        cand = c | (64'd1 << b);
        if (cand * cand * cand * steps <= target) c = cand;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/rgbluv_ram.sv @@
// Generic single write port RAM with registered read.
module rgbluv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/rgbluv_matrix.sv @@
// RGB to XYZ matrix: registered products, then registered sums.
module rgbluv_matrix #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [rgbluv_pkg::CHAN_W-1:0]   red,
  input  logic [rgbluv_pkg::CHAN_W-1:0]   green,
  input  logic [rgbluv_pkg::CHAN_W-1:0]   blue,
  output logic [rgbluv_pkg::SUM_W-1:0]    xf_r,
  output logic [rgbluv_pkg::SUM_W-1:0]    yf_r,
  output logic [rgbluv_pkg::SUM_W-1:0]    zf_r
);

  localparam int MB = (CHANNEL_BITS < rgbluv_pkg::CHAN_W) ? CHANNEL_BITS : rgbluv_pkg::CHAN_W;
  localparam logic [rgbluv_pkg::CHAN_W-1:0] MASK =
    rgbluv_pkg::CHAN_W'((64'd1 << MB) - 64'd1);

  logic [rgbluv_pkg::CHAN_W-1:0] r, g, b;
  logic [rgbluv_pkg::PROD_W-1:0] p_r [9];

  assign r = red & MASK;
  assign g = green & MASK;
  assign b = blue & MASK;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= rgbluv_pkg::KXR * r;
      p_r[1] <= rgbluv_pkg::KXG * g;
      p_r[2] <= rgbluv_pkg::KXB * b;
      p_r[3] <= rgbluv_pkg::KYR * r;
      p_r[4] <= rgbluv_pkg::KYG * g;
      p_r[5] <= rgbluv_pkg::KYB * b;
      p_r[6] <= rgbluv_pkg::KZR * r;
      p_r[7] <= rgbluv_pkg::KZG * g;
      p_r[8] <= rgbluv_pkg::KZB * b;
      xf_r <= rgbluv_pkg::SUM_W'(p_r[0]) + rgbluv_pkg::SUM_W'(p_r[1])
            + rgbluv_pkg::SUM_W'(p_r[2]);
      yf_r <= rgbluv_pkg::SUM_W'(p_r[3]) + rgbluv_pkg::SUM_W'(p_r[4])
            + rgbluv_pkg::SUM_W'(p_r[5]);
      zf_r <= rgbluv_pkg::SUM_W'(p_r[6]) + rgbluv_pkg::SUM_W'(p_r[7])
            + rgbluv_pkg::SUM_W'(p_r[8]);
    end
  end

endmodule

@@ rtl/rgbluv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rgbluv_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 25,
  parameter int QUO_W = 26
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r  [QUO_W];
  logic [QUO_W-1:0] nbit_r [QUO_W];
  logic [QUO_W-1:0] q_r    [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] nbit_in;
    logic [QUO_W-1:0] q_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      // upper bits are below den since the quotient fits in QUO_W bits
      assign rem_in  = DEN_W'(num[NUM_W-1:QUO_W]);
      assign nbit_in = num[QUO_W-1:0];
      assign q_in    = '0;
      assign den_in  = den;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign nbit_in = nbit_r[k-1];
      assign q_in    = q_r[k-1];
      assign den_in  = den_r[k-1];
    end

    assign t  = {rem_in, nbit_in[QUO_W-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
        nbit_r[k] <= nbit_in << 1;
        q_r[k]    <= {q_in[QUO_W-2:0], ge};
        den_r[k]  <= den_in;
      end
    end
  end

  assign quo = q_r[QUO_W-1];

endmodule

@@ rtl/rgbluv_chroma.sv @@
// Chroma term: L times (ratio minus white), offset, round, clamp.
module rgbluv_chroma (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rgbluv_pkg::CHAN_W-1:0]     l16,
  input  logic [rgbluv_pkg::QUO_W-1:0]      quo,
  input  logic                              zero_den,
  input  logic [rgbluv_pkg::DIFF_W-1:0]     white,
  input  logic [rgbluv_pkg::CHAN_W-1:0]     offset,
  output logic [rgbluv_pkg::CHAN_W-1:0]     chroma_r
);

  localparam int AW = rgbluv_pkg::ACC_W;

  logic signed [rgbluv_pkg::DIFF_W-1:0] diff;
  logic signed [rgbluv_pkg::TERM_W-1:0] term_r;
  logic signed [AW-1:0]                 acc;

  assign diff = $signed(rgbluv_pkg::DIFF_W'(quo) - white);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_den) begin
        term_r <= '0;
      end else begin
        term_r <= $signed({1'b0, l16}) * diff;
      end
    end
  end

  assign acc = $signed({{(AW - rgbluv_pkg::CHAN_W - 20){1'b0}}, offset, 20'd0})
             + AW'(term_r) + $signed(AW'(1) << 19);

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc < 0) begin
        chroma_r <= '0;
      end else if (acc[AW-1:20] > (AW-20)'(16'hFFFF)) begin
        chroma_r <= 16'hFFFF;
      end else begin
        chroma_r <= acc[35:20];
      end
    end
  end

endmodule

@@ rtl/rgb_to_luv_converter_unit.sv @@
// RGB to Luv converter: a 31-stage pipeline (2 matrix stages, 1 setup stage,
// one stage per quotient bit in the two 26-bit dividers, 2 chroma stages), and
// one pixel is taken per clock once the table is filled and while the pipe is
// not held. The whole pipe holds while a finished word waits at the output.
// After reset the lightness table RAM is filled from constants, one entry a
// cycle, so no pixel is taken until all TABLE_STEPS+1 entries (1025 at the
// default) are written.
module rgb_to_luv_converter_unit #(
  parameter int TABLE_STEPS  = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_lightness,
  output logic [15:0] out_chroma_u,
  output logic [15:0] out_chroma_v
);

  localparam int QW    = rgbluv_pkg::QUO_W;
  localparam int NST   = QW + 5;
  localparam int DEPTH = TABLE_STEPS + 1;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int YW    = rgbluv_pkg::SUM_W + 13;
  localparam int SUMW  = rgbluv_pkg::SUM_W;

  logic [NST-1:0] vld_r;
  logic           en;
  logic           fill_done_r;
  logic [IDXW-1:0] fill_cnt_r;
  logic [15:0]    rom_const [DEPTH];

  logic [SUMW-1:0] xf, yf, zf;
  logic [rgbluv_pkg::XQ_W-1:0] xq, yq, zq;
  logic [YW-1:0]   yscaled;
  logic [YW-1:0]   idx_full;
  logic [IDXW-1:0] idx_r;
  logic [rgbluv_pkg::DEN_W-1:0] den_r;
  logic [rgbluv_pkg::NUM_W-1:0] num_u_r, num_v_r;
  logic            zero_r;
  logic [15:0]     rom_q;
  logic [QW-1:0]   quo_u, quo_v;
  logic            z_d_r [QW];
  logic [15:0]     l_d_r [QW+1];

  // table contents, worked out at elaboration
  for (genvar g = 0; g <= TABLE_STEPS; g++) begin : g_rom
    localparam longint unsigned GI = longint'(g);
    localparam longint unsigned TS = longint'(TABLE_STEPS);
    localparam longint unsigned CR = rgbluv_pkg::cbrt_q17(GI, TS);
    localparam longint unsigned AA = 64'd116 * CR;
    localparam longint unsigned BB = 64'd16 << 17;
    localparam longint unsigned NB = (AA > BB) ? AA - BB : 64'd0;
    localparam longint unsigned VB =
      (NB * 64'd65536 + 64'd135 * 64'd131072) / (64'd270 * 64'd131072);
    localparam longint unsigned SD = TS * 64'd7290;
    localparam longint unsigned VS = (GI * 64'd24389 * 64'd65536 + SD / 64'd2) / SD;
    localparam longint unsigned VV = (GI * 64'd24389 > 64'd216 * TS) ? VB : VS;
    assign rom_const[g] = 16'((VV > 64'd65535) ? 64'd65535 : VV);
  end

  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en && fill_done_r;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fill_done_r <= 1'b0;
      fill_cnt_r  <= '0;
    end else begin
      if (en) vld_r <= {vld_r[NST-2:0], in_valid && in_ready};
      if (!fill_done_r) begin
        if (fill_cnt_r == IDXW'(TABLE_STEPS)) fill_done_r <= 1'b1;
        else fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  rgbluv_matrix #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_matrix (
    .clk  (clk),
    .en   (en),
    .red  (in_red),
    .green(in_green),
    .blue (in_blue),
    .xf_r (xf),
    .yf_r (yf),
    .zf_r (zf)
  );

  assign xq       = rgbluv_pkg::XQ_W'(xf >> CHANNEL_BITS);
  assign yq       = rgbluv_pkg::XQ_W'(yf >> CHANNEL_BITS);
  assign zq       = rgbluv_pkg::XQ_W'(zf >> CHANNEL_BITS);
  assign yscaled  = YW'(yf) * YW'(TABLE_STEPS);
  assign idx_full = yscaled >> (CHANNEL_BITS + 20);

  // setup stage: denominator, numerators, table index
  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= rgbluv_pkg::DEN_W'(xq) + rgbluv_pkg::DEN_W'(yq) * 25'd15
               + rgbluv_pkg::DEN_W'(zq) * 25'd3;
      zero_r  <= (xq == '0) && (yq == '0) && (zq == '0);
      num_u_r <= {rgbluv_pkg::NUM_W'(26'(xq) * 26'd52)} << 20;
      num_v_r <= {rgbluv_pkg::NUM_W'(27'(yq) * 27'd117)} << 20;
      idx_r   <= (idx_full > YW'(TABLE_STEPS)) ? IDXW'(TABLE_STEPS) : IDXW'(idx_full);
    end
  end

  rgbluv_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_lrom (
    .clk    (clk),
    .we     (!fill_done_r),
    .waddr  (fill_cnt_r),
    .wdata  (rom_const[fill_cnt_r]),
    .re     (en),
    .raddr  (idx_r),
    .rdata_r(rom_q)
  );

  rgbluv_div #(
    .NUM_W(rgbluv_pkg::NUM_W),
    .DEN_W(rgbluv_pkg::DEN_W),
    .QUO_W(QW)
  ) u_div_u (
    .clk(clk),
    .en (en),
    .num(num_u_r),
    .den(den_r),
    .quo(quo_u)
  );

  rgbluv_div #(
    .NUM_W(rgbluv_pkg::NUM_W),
    .DEN_W(rgbluv_pkg::DEN_W),
    .QUO_W(QW)
  ) u_div_v (
    .clk(clk),
    .en (en),
    .num(num_v_r),
    .den(den_r),
    .quo(quo_v)
  );

  // side data delayed to line up with the divider outputs
  always_ff @(posedge clk) begin
    if (en) begin
      z_d_r[0] <= zero_r;
      l_d_r[0] <= rom_q;
      for (int j = 1; j < QW; j++) z_d_r[j] <= z_d_r[j-1];
      for (int j = 1; j <= QW; j++) l_d_r[j] <= l_d_r[j-1];
    end
  end

  rgbluv_chroma u_chroma_u (
    .clk     (clk),
    .en      (en),
    .l16     (l_d_r[QW-2]),
    .quo     (quo_u),
    .zero_den(z_d_r[QW-1]),
    .white   (rgbluv_pkg::WHITE_U13),
    .offset  (rgbluv_pkg::OFF_U),
    .chroma_r(out_chroma_u)
  );

  rgbluv_chroma u_chroma_v (
    .clk     (clk),
    .en      (en),
    .l16     (l_d_r[QW-2]),
    .quo     (quo_v),
    .zero_den(z_d_r[QW-1]),
    .white   (rgbluv_pkg::WHITE_V13),
    .offset  (rgbluv_pkg::OFF_V),
    .chroma_r(out_chroma_v)
  );

  assign out_lightness = l_d_r[QW];

endmodule
